@@ sv/mvs_pkg.sv @@
// Shared widths, step counts and payload types for the mean/variance/stddev block.
`default_nettype none

package mvs_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 8;

  localparam int CNT_W  = 11;
  localparam int SUM_W  = 27;
  localparam int SQ_W   = 41;
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 39;
  localparam int SD_W   = 24;

  localparam int MAG_W    = SUM_W - 1;
  localparam int ALU_W    = 52;
  localparam int D_W      = ALU_W - 1;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int SH_W     = 64;
  localparam int STEP_W   = 6;
  localparam int MEAN_N_W = MAG_W + FRAC_W + 1;
  localparam int DVAR_N_W = D_W + FRAC_W;
  localparam int SQRT_STEPS = (VAR_W + FRAC_W + 1) / 2;
  localparam int SQRT_N_W   = 2 * SQRT_STEPS;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic             ovf;
  } mvs_tot_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [MEAN_W-1:0] mean_q8;
    logic [VAR_W-1:0]  variance_q8;
    logic [SD_W-1:0]   stddev_q8;
    logic              overflowed;
  } mvs_res_t;

endpackage

`default_nettype wire

@@ sv/mvs_if.sv @@
// Sample and result channel interfaces.
`default_nettype none

interface mvs_in_if;
  import mvs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface mvs_out_if;
  import mvs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CNT_W-1:0]         count;
  logic signed [MEAN_W-1:0] mean_q8;
  logic [VAR_W-1:0]         variance_q8;
  logic [SD_W-1:0]          stddev_q8;
  logic                     overflowed;

  modport source (output valid, count, mean_q8, variance_q8, stddev_q8, overflowed,
                  input ready);
  modport sink (input valid, count, mean_q8, variance_q8, stddev_q8, overflowed,
                output ready);
endinterface

`default_nettype wire

@@ sv/mean_variance_stddev.sv @@
// Streaming population mean, variance and standard deviation over sets of samples.
//
// Input channel in_ch: one signed sample per request, last marks the final sample of
// a set. Samples are taken one per cycle while ready is high. Past 1024 kept samples,
// further samples of the set are dropped and the set's result reports overflowed.
// Output channel out_ch: one request per set with count, mean, variance and stddev,
// all fractions in Q8.
// The finish runs through one shared add/subtract unit, one bit per cycle in its
// multiplies, divisions and square root, plus four moves. In order: totals pickup,
// multiplies n*sq and |sum|*|sum|, subtract, multiply n*n, variance division,
// rounding add, mean division, square root, output load.
// in_ch.ready drops for one cycle after every last sample while the engine picks up
// the totals, and stays low longer when a set closes before the previous one has left
// the shared unit.
// A stalled receiver holds the result in the output register; the engine then waits
// and, behind it, a further closed set holds off the input.
// Reset (rst_n low, synchronous) empties the running set and drops any pending result.
`default_nettype none

module mean_variance_stddev (
  input  logic       clk,
  input  logic       rst_n,
  mvs_in_if.sink     in_ch,
  mvs_out_if.source  out_ch
);
  import mvs_pkg::*;

  mvs_tot_t tot;
  logic     tot_vld;
  logic     tot_take;
  mvs_res_t res;
  logic     res_vld;
  logic     res_take;
  logic     out_vld_r;
  mvs_res_t out_res_r;

  mvs_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .tot      (tot),
    .tot_vld  (tot_vld),
    .tot_take (tot_take)
  );

  mvs_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .tot      (tot),
    .tot_vld  (tot_vld),
    .tot_take (tot_take),
    .res      (res),
    .res_vld  (res_vld),
    .res_take (res_take)
  );

  // load the output register when it is empty or being drained
  assign res_take = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld && res_take) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.count       = out_res_r.count;
  assign out_ch.mean_q8     = out_res_r.mean_q8;
  assign out_ch.variance_q8 = out_res_r.variance_q8;
  assign out_ch.stddev_q8   = out_res_r.stddev_q8;
  assign out_ch.overflowed  = out_res_r.overflowed;

  a_close_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.last |=> tot_vld)
    else $error("closed set did not reach the engine");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.count != '0) && (out_ch.count <= CNT_W'(MAX_SAMPLES)))
    else $error("result count out of range");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflowed |-> out_ch.count == CNT_W'(MAX_SAMPLES))
    else $error("overflow flagged on a set that was not full");

endmodule

`default_nettype wire

@@ sv/mvs_accum.sv @@
// Sample accumulator: count, sum and sum of squares, handed off at the end of a set.
`default_nettype none

module mvs_accum (
  input  logic              clk,
  input  logic              rst_n,
  mvs_in_if.sink            in_ch,
  output mvs_pkg::mvs_tot_t tot,
  output logic              tot_vld,
  input  logic              tot_take
);
  import mvs_pkg::*;

  logic [CNT_W-1:0]          cnt_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [SQ_W-1:0]           sq_r;
  logic                      ovf_r;
  logic                      tot_vld_r;
  mvs_tot_t                  tot_r;

  logic [CNT_W-1:0]          cnt_nxt;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic [SQ_W-1:0]           sq_nxt;
  logic                      ovf_nxt;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic                      keep;
  logic                      accept;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !tot_vld_r;
  assign keep        = cnt_r < CNT_W'(MAX_SAMPLES);
  assign prod        = in_ch.sample * in_ch.sample;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    ovf_nxt = ovf_r;
    if (keep) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      sum_nxt = sum_r + SUM_W'(in_ch.sample);
      sq_nxt  = sq_r + SQ_W'($unsigned(prod));
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sum_r     <= '0;
      sq_r      <= '0;
      ovf_r     <= 1'b0;
      tot_vld_r <= 1'b0;
    end else begin
      if (tot_take) begin
        tot_vld_r <= 1'b0;
      end
      if (accept) begin
        if (in_ch.last) begin
          // close the set: hand totals over and start the next set from zero
          tot_vld_r <= 1'b1;
          cnt_r     <= '0;
          sum_r     <= '0;
          sq_r      <= '0;
          ovf_r     <= 1'b0;
        end else begin
          cnt_r <= cnt_nxt;
          sum_r <= sum_nxt;
          sq_r  <= sq_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last) begin
      tot_r.cnt <= cnt_nxt;
      tot_r.sum <= sum_nxt;
      tot_r.sq  <= sq_nxt;
      tot_r.ovf <= ovf_nxt;
    end
  end

  assign tot     = tot_r;
  assign tot_vld = tot_vld_r;

endmodule

`default_nettype wire

@@ sv/mvs_engine.sv @@
// Finishing engine: one shared add/subtract unit runs multiplies, divides and a square root.
`default_nettype none

module mvs_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  mvs_pkg::mvs_tot_t tot,
  input  logic              tot_vld,
  output logic              tot_take,
  output mvs_pkg::mvs_res_t res,
  output logic              res_vld,
  input  logic              res_take
);
  import mvs_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MNQ   = 4'd1;
  localparam logic [3:0] ST_MSS   = 4'd2;
  localparam logic [3:0] ST_DSUB  = 4'd3;
  localparam logic [3:0] ST_MNN   = 4'd4;
  localparam logic [3:0] ST_DVAR  = 4'd5;
  localparam logic [3:0] ST_MADD  = 4'd6;
  localparam logic [3:0] ST_DMEAN = 4'd7;
  localparam logic [3:0] ST_SQRT  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ALU_W-1:0]  acc_r, acc_nxt;
  logic [ALU_W-1:0]  t_r, t_nxt;
  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [VAR_W-1:0]  res_r, res_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [MAG_W-1:0]  smag_r, smag_nxt;
  logic              neg_r, neg_nxt;
  logic [SQ_W-1:0]   q_r, q_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [SD_W-1:0]   sd_r, sd_nxt;

  logic [ALU_W-1:0]  alu_a, alu_b, mcand;
  logic              alu_sub;
  logic [ALU_W:0]    alu_sum;
  logic [ALU_W-1:0]  alu_y;
  logic              alu_co;
  logic [ALU_W-1:0]  rem_step;
  logic [VAR_W-1:0]  res_step;
  logic              last_step;
  logic [SUM_W-1:0]  tot_mag;
  logic [MEAN_W-1:0] qmean;
  logic [DVAR_N_W-1:0] dvar_num;
  logic [SQRT_N_W-1:0] sqrt_x;

  // multiplicand and divisor follow the phase
  always_comb begin
    case (state_r)
      ST_MNQ:  mcand = ALU_W'(q_r);
      ST_MSS:  mcand = ALU_W'(smag_r);
      ST_MNN:  mcand = ALU_W'(n_r);
      default: mcand = '0;
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_MNQ, ST_MSS, ST_MNN: begin
        alu_a = {acc_r[ALU_W-2:0], 1'b0};
        alu_b = sh_r[SH_W-1] ? mcand : '0;
      end
      ST_DSUB: begin
        alu_a   = t_r;
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      ST_DVAR: begin
        alu_a   = {acc_r[ALU_W-2:0], sh_r[SH_W-1]};
        alu_b   = ALU_W'(den_r);
        alu_sub = 1'b1;
      end
      ST_MADD: begin
        alu_a = ALU_W'({smag_r, {(FRAC_W + 1){1'b0}}});
        alu_b = ALU_W'(n_r);
      end
      ST_DMEAN: begin
        alu_a   = {acc_r[ALU_W-2:0], sh_r[SH_W-1]};
        alu_b   = ALU_W'({n_r, 1'b0});
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = {acc_r[ALU_W-3:0], sh_r[SH_W-1 -: 2]};
        alu_b   = ALU_W'({res_r, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}}
                  + {{ALU_W{1'b0}}, alu_sub};
  assign alu_y    = alu_sum[ALU_W-1:0];
  assign alu_co   = alu_sum[ALU_W];
  // restoring step: keep the difference only when it did not go negative
  assign rem_step = alu_co ? alu_y : alu_a;
  assign res_step = {res_r[VAR_W-2:0], alu_co};
  assign last_step = (step_r == STEP_W'(1));

  assign tot_mag  = tot.sum[SUM_W-1] ? (~tot.sum + SUM_W'(1)) : tot.sum;
  assign qmean    = res_step[MEAN_W-1:0];
  assign dvar_num = {t_r[D_W-1:0], {FRAC_W{1'b0}}};
  assign sqrt_x   = SQRT_N_W'({var_r, {FRAC_W{1'b0}}});

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    t_nxt     = t_r;
    sh_nxt    = sh_r;
    res_nxt   = res_r;
    n_nxt     = n_r;
    smag_nxt  = smag_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    den_nxt   = den_r;
    var_nxt   = var_r;
    mean_nxt  = mean_r;
    sd_nxt    = sd_r;
    tot_take  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (tot_vld) begin
          tot_take  = 1'b1;
          n_nxt     = tot.cnt;
          neg_nxt   = tot.sum[SUM_W-1];
          smag_nxt  = tot_mag[MAG_W-1:0];
          q_nxt     = tot.sq;
          ovf_nxt   = tot.ovf;
          acc_nxt   = '0;
          sh_nxt    = SH_W'(tot.cnt) << (SH_W - CNT_W);
          step_nxt  = STEP_W'(CNT_W);
          state_nxt = ST_MNQ;
        end
      end
      ST_MNQ, ST_MSS, ST_MNN: begin
        acc_nxt  = alu_y;
        sh_nxt   = sh_r << 1;
        step_nxt = step_r - STEP_W'(1);
        if (last_step) begin
          if (state_r == ST_MNQ) begin
            t_nxt     = alu_y;
            acc_nxt   = '0;
            sh_nxt    = SH_W'(smag_r) << (SH_W - MAG_W);
            step_nxt  = STEP_W'(MAG_W);
            state_nxt = ST_MSS;
          end else if (state_r == ST_MSS) begin
            state_nxt = ST_DSUB;
          end else begin
            den_nxt   = alu_y[DEN_W-1:0];
            acc_nxt   = '0;
            res_nxt   = '0;
            sh_nxt    = SH_W'(dvar_num) << (SH_W - DVAR_N_W);
            step_nxt  = STEP_W'(DVAR_N_W);
            state_nxt = ST_DVAR;
          end
        end
      end
      ST_DSUB: begin
        t_nxt     = alu_y;
        acc_nxt   = '0;
        sh_nxt    = SH_W'(n_r) << (SH_W - CNT_W);
        step_nxt  = STEP_W'(CNT_W);
        state_nxt = ST_MNN;
      end
      ST_DVAR, ST_DMEAN: begin
        acc_nxt  = rem_step;
        res_nxt  = res_step;
        sh_nxt   = sh_r << 1;
        step_nxt = step_r - STEP_W'(1);
        if (last_step) begin
          if (state_r == ST_DVAR) begin
            var_nxt   = res_step;
            state_nxt = ST_MADD;
          end else begin
            mean_nxt  = neg_r ? (MEAN_W'(0) - qmean) : qmean;
            acc_nxt   = '0;
            res_nxt   = '0;
            sh_nxt    = SH_W'(sqrt_x) << (SH_W - SQRT_N_W);
            step_nxt  = STEP_W'(SQRT_STEPS);
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_MADD: begin
        acc_nxt   = '0;
        res_nxt   = '0;
        sh_nxt    = SH_W'(alu_y[MEAN_N_W-1:0]) << (SH_W - MEAN_N_W);
        step_nxt  = STEP_W'(MEAN_N_W);
        state_nxt = ST_DMEAN;
      end
      ST_SQRT: begin
        acc_nxt  = rem_step;
        res_nxt  = res_step;
        sh_nxt   = sh_r << 2;
        step_nxt = step_r - STEP_W'(1);
        if (last_step) begin
          sd_nxt    = res_step[SD_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    t_r    <= t_nxt;
    sh_r   <= sh_nxt;
    res_r  <= res_nxt;
    n_r    <= n_nxt;
    smag_r <= smag_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
    den_r  <= den_nxt;
    var_r  <= var_nxt;
    mean_r <= mean_nxt;
    sd_r   <= sd_nxt;
  end

  assign res_vld         = (state_r == ST_DONE);
  assign res.count       = n_r;
  assign res.mean_q8     = mean_r;
  assign res.variance_q8 = var_r;
  assign res.stddev_q8   = sd_r;
  assign res.overflowed  = ovf_r;

endmodule

`default_nettype wire

@@ dv/mean_variance_stddev_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the streaming mean, variance and stddev block.
module mean_variance_stddev_test;
  import mvs_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_req_t;

  localparam int TARGET_SAMPLES = 1950;
  localparam int MIN_RANDOM_SETS = 12;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mvs_in_if  in_ch ();
  mvs_out_if out_ch ();

  mean_variance_stddev i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sample_req_t sample_queue[$];
  mvs_res_t    expected_stats[$];

  // Running set as the block should hold it
  logic [CNT_W-1:0]        acc_count = '0;
  logic signed [SUM_W-1:0] acc_sum = '0;
  logic [SQ_W-1:0]         acc_sqsum = '0;
  logic                    acc_dropped = 1'b0;

  int samples_queued = 0;
  int samples_taken = 0;
  int sets_closed = 0;
  int stats_checked = 0;
  int error_count = 0;
  int random_sets = 0;

  int  in_gap = 0;
  int  in_quiet = 0;
  int  out_gap = 0;
  int  out_quiet = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted sample into the running set; close the set on last
  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] x, input logic last);
    longint          sx;
    longint unsigned n;
    longint unsigned smag;
    longint unsigned q;
    longint unsigned dev;
    longint unsigned var_q8;
    longint unsigned mean_bits;
    longint unsigned sd;
    bit              neg;
    mvs_res_t        res;
    sx = x;
    if (acc_count >= MAX_SAMPLES) begin
      acc_dropped = 1'b1;
    end else begin
      acc_count = acc_count + 1'b1;
      acc_sum = acc_sum + SUM_W'(sx);
      acc_sqsum = acc_sqsum + SQ_W'(sx * sx);
    end
    if (!last) return;
    n = acc_count;
    mean_bits = 0;
    var_q8 = 0;
    sd = 0;
    if (n != 0) begin
      neg = acc_sum < 0;
      sx = acc_sum;
      smag = neg ? -sx : sx;
      // round half away from zero on the magnitude
      q = ((smag << FRAC_W) * 2 + n) / (2 * n);
      mean_bits = neg ? -q : q;
      dev = n * acc_sqsum - smag * smag;
      var_q8 = (dev << FRAC_W) / (n * n);
      sd = floor_sqrt(var_q8 << FRAC_W);
    end
    res.count = n[CNT_W-1:0];
    res.mean_q8 = mean_bits[MEAN_W-1:0];
    res.variance_q8 = var_q8[VAR_W-1:0];
    res.stddev_q8 = sd[SD_W-1:0];
    res.overflowed = acc_dropped;
    expected_stats.insert(expected_stats.size(), res);
    sets_closed++;
    acc_count = '0;
    acc_sum = '0;
    acc_sqsum = '0;
    acc_dropped = 1'b0;
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    sample_req_t req;
    req.sample = s;
    req.last = last;
    sample_queue.insert(sample_queue.size(), req);
    samples_queued++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style);
    logic [31:0] v;
    int          k;
    v = $urandom();
    case (style)
      0: return v[SAMPLE_W-1:0];
      1: begin
        k = $urandom_range(0, 5);
        case (k)
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd32767;
          3: return 16'sd0;
          4: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      2: return SAMPLE_W'($urandom_range(0, 8) - 4);
      default: begin
        // cluster near the two rails
        k = $urandom_range(32700, 32767);
        return v[0] ? SAMPLE_W'(k) : SAMPLE_W'(-k - 1);
      end
    endcase
  endfunction

  task automatic push_random_set();
    int len;
    int style;
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) len = $urandom_range(1, 6);
    else if (r < 93) len = $urandom_range(7, 40);
    else len = $urandom_range(150, 200);
    style = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) push_sample(pick_sample(style), i == len - 1);
    random_sets++;
  endtask

  // Sender: offer queued samples, hold each until taken
  always @(posedge clk) begin
    sample_req_t req;
    int          r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid) begin
        accumulate_sample(in_ch.sample, in_ch.last);
        samples_taken++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        req = sample_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.sample <= req.sample;
        in_ch.last <= req.last;
        if (in_quiet > 0) begin
          in_quiet--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) in_quiet = $urandom_range(100, 400);
          else if (r >= 55) in_gap = draw_gap();
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off once results are flowing
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && stats_checked >= 8) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_quiet > 0) begin
        out_quiet--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) out_quiet = $urandom_range(50, 300);
        else if (r < 30) out_gap = draw_gap();
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    mvs_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result, count %0d mean %0d", $time, out_ch.count,
                 out_ch.mean_q8);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        if (out_ch.count !== want.count)
          note_mismatch("count", want.count, out_ch.count);
        if (out_ch.mean_q8 !== want.mean_q8)
          note_mismatch("mean_q8", $signed(want.mean_q8), out_ch.mean_q8);
        if (out_ch.variance_q8 !== want.variance_q8)
          note_mismatch("variance_q8", want.variance_q8, out_ch.variance_q8);
        if (out_ch.stddev_q8 !== want.stddev_q8)
          note_mismatch("stddev_q8", want.stddev_q8, out_ch.stddev_q8);
        if (out_ch.overflowed !== want.overflowed)
          note_mismatch("overflowed", want.overflowed, out_ch.overflowed);
      end
      stats_checked++;
    end
  end

  initial begin
    #(25_000_000);
    $display("mean_variance_stddev_test: FAIL");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;

    // Short sets: rails, exact halves, rounding both ways on each sign
    push_sample(16'sd0, 1'b1);
    push_sample(16'sd32767, 1'b1);
    push_sample(-16'sd32768, 1'b1);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd32767, 1'b1);
    push_sample(16'sd32767, 1'b0);
    push_sample(16'sd32767, 1'b1);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd2, 1'b1);
    push_sample(-16'sd1, 1'b0);
    push_sample(-16'sd2, 1'b1);
    for (int k = 0; k < 4; k++) begin
      push_sample((k < 2) ? SAMPLE_W'(k + 1) : SAMPLE_W'(-(k - 1)), 1'b0);
      push_sample(16'sd0, 1'b0);
      push_sample(16'sd0, 1'b1);
    end

    // Full set with two dropped samples; last lands on a dropped one, mean is a +0.5 tie
    for (int i = 0; i < MAX_SAMPLES; i++)
      push_sample((i == 1) ? -16'sd32765 : (i % 2 == 0) ? 16'sd32767 : -16'sd32767, 1'b0);
    push_sample(16'sd12345, 1'b0);
    push_sample(-16'sd32768, 1'b1);

    // Half-full set of rail swings whose mean is a -0.5 tie
    for (int i = 0; i < 512; i++)
      push_sample((i == 0) ? -16'sd32513 : (i % 2 == 0) ? -16'sd32768 : 16'sd32767,
                  i == 511);

    while (samples_queued < TARGET_SAMPLES || random_sets < MIN_RANDOM_SETS)
      push_random_set();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (samples_taken == samples_queued);
    wait (expected_stats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d sets (%0d random), checked %0d results.",
             samples_taken, sets_closed, random_sets, stats_checked);
    $display("Covered rail values, rounding ties, a dropped-sample set and a %0d-cycle hold-off.",
             HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("mean_variance_stddev_test: PASS");
    end else begin
      $display("mean_variance_stddev_test: FAIL");
    end
    $finish;
  end

endmodule

@@ mean_variance_stddev.f @@
sv/mvs_pkg.sv
sv/mvs_if.sv
sv/mvs_accum.sv
sv/mvs_engine.sv
sv/mean_variance_stddev.sv
dv/mean_variance_stddev_test.sv
